// File: rtl/bfs_pkg.sv
// Shared types and constants for the bounded queue with search.
package bfs_pkg;

    // Default ring depth and fixed field widths
    localparam int DEPTH_DEF = 32;
    localparam int WORD_W    = 32;
    localparam int CAP_W     = 6;
    localparam int CMP_W     = CAP_W + 1;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Request kinds
    typedef enum logic [1:0] {
        ACT_ENQ    = 2'd0,
        ACT_DEQ    = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ENQ   = 3'd0,
        ST_OVF   = 3'd1,
        ST_DEQ   = 3'd2,
        ST_UNF   = 3'd3,
        ST_FOUND = 3'd4,
        ST_MISS  = 3'd5,
        ST_DWORD = 3'd6,
        ST_DEND  = 3'd7
    } t_status;

endpackage

// File: rtl/bfs_mem.sv
// Ring store: one write port, one read port, registered read data.
module bfs_mem #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF,
    parameter int WIDTH = bfs_pkg::WORD_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Synchronous write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bfs_ctrl.sv
// Request sequencer: ring pointers, fill count, store walk and result register.
module bfs_ctrl #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  bfs_pkg::t_action              i_action,
    input  logic signed [bfs_pkg::WORD_W-1:0] i_value,
    input  logic [bfs_pkg::CAP_W-1:0]     i_capacity,
    output logic                          o_busy,
    output logic                          o_strobe,
    output bfs_pkg::t_status              o_status,
    output logic signed [bfs_pkg::WORD_W-1:0] o_word,
    output logic                          o_last,
    output logic [CW-1:0]                 o_count,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [bfs_pkg::WORD_W-1:0]    o_wdata,
    output logic [AW-1:0]                 o_raddr,
    input  logic [bfs_pkg::WORD_W-1:0]    i_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_WALK,
        S_END
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_left, n_left;
    bfs_pkg::t_action r_act, n_act;
    logic [bfs_pkg::WORD_W-1:0] r_val, n_val;
    logic r_strobe, n_strobe;
    bfs_pkg::t_status r_status, n_status;
    logic [bfs_pkg::WORD_W-1:0] r_word, n_word;
    logic r_last, n_last;
    logic w_full;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [bfs_pkg::CMP_W-1:0] CMP_W_EXT(input logic [CW-1:0] c);
        CMP_W_EXT = bfs_pkg::CMP_W'(c);
    endfunction

    // Effective limit is the smaller of capacity and ring depth
    assign w_full = (CMP_W_EXT(r_count) >= bfs_pkg::CMP_W'(DEPTH)) ||
                    (CMP_W_EXT(r_count) >= bfs_pkg::CMP_W'(i_capacity));

    // Next-state and result logic
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_act    = r_act;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_status = r_status;
        n_word   = r_word;
        n_last   = r_last;
        o_we     = 1'b0;
        o_waddr  = r_tail;
        o_wdata  = i_value;
        o_raddr  = (r_state == S_IDLE) ? r_head : r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_act = i_action;
                    n_val = i_value;
                    case (i_action)
                        bfs_pkg::ACT_ENQ: begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            if (w_full) begin
                                n_status = bfs_pkg::ST_OVF;
                                n_word   = '0;
                            end else begin
                                o_we     = 1'b1;
                                n_tail   = f_next(r_tail);
                                n_count  = r_count + CW'(1);
                                n_status = bfs_pkg::ST_ENQ;
                                n_word   = i_value;
                            end
                        end
                        bfs_pkg::ACT_DEQ: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                                n_status = bfs_pkg::ST_UNF;
                                n_word   = '0;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        default: begin
                            // dump and search walk from the head
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                                if (i_action == bfs_pkg::ACT_DUMP) begin
                                    n_status = bfs_pkg::ST_DEND;
                                    n_word   = '0;
                                end else begin
                                    n_status = bfs_pkg::ST_MISS;
                                    n_word   = i_value;
                                end
                            end else begin
                                n_ptr   = f_next(r_head);
                                n_left  = r_count;
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_status = bfs_pkg::ST_DEQ;
                n_word   = i_rdata;
                n_head   = f_next(r_head);
                n_count  = r_count - CW'(1);
                n_state  = S_IDLE;
            end
            S_WALK: begin
                // read data belongs to the previous address; next read issued now
                n_ptr  = f_next(r_ptr);
                n_left = r_left - CW'(1);
                if (r_act == bfs_pkg::ACT_DUMP) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b0;
                    n_status = bfs_pkg::ST_DWORD;
                    n_word   = i_rdata;
                    if (r_left == CW'(1)) begin
                        n_state = S_END;
                    end
                end else if (i_rdata == r_val) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_status = bfs_pkg::ST_FOUND;
                    n_word   = r_val;
                    n_state  = S_IDLE;
                end else if (r_left == CW'(1)) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_status = bfs_pkg::ST_MISS;
                    n_word   = r_val;
                    n_state  = S_IDLE;
                end
            end
            S_END: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_status = bfs_pkg::ST_DEND;
                n_word   = '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_act    <= n_act;
        r_val    <= n_val;
        r_status <= n_status;
        r_word   <= n_word;
        r_last   <= n_last;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_word   = r_word;
    assign o_last   = r_last;
    assign o_count  = r_count;

endmodule

// File: rtl/bounded_fifo_with_search.sv
// Top level: bounded queue with search, capacity register and checks.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------
//  request   | start, busy            | i_action, i_value
//  result    | o_strobe (one cycle)   | o_status, o_word, o_last
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata
//
// Enqueue, and any request that finds the queue empty, completes in the
// accept cycle: its registered result shows in the next cycle and busy stays low.
// Dequeue makes one store read and returns the word from S_DEQ. Dump and
// search walk the ring from the head in S_WALK, one store read per cycle.
// Reset is synchronous and clears pointers, count and capacity (to 32).
// Results cannot be stalled; each is valid for the single strobe cycle.
module bounded_fifo_with_search #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic signed [bfs_pkg::WORD_W-1:0]   i_value,
    output logic                                o_strobe,
    output logic [2:0]                          o_status,
    output logic signed [bfs_pkg::WORD_W-1:0]   o_word,
    output logic                                o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [bfs_pkg::CAP_W-1:0] r_capacity;
    logic                      w_cfg_wr;
    logic                      w_cap_sel;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [AW-1:0]             w_raddr;
    logic [bfs_pkg::WORD_W-1:0] w_wdata;
    logic [bfs_pkg::WORD_W-1:0] w_rdata;
    logic [CW-1:0]             w_count;
    bfs_pkg::t_status          w_status;

    // Configuration register
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cap_sel = (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = w_cap_sel ? 32'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bfs_pkg::CAP_RESET;
        end else if (w_cfg_wr && w_cap_sel) begin
            r_capacity <= pwdata[bfs_pkg::CAP_W-1:0];
        end
    end

    // Sequencer
    bfs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_action   (bfs_pkg::t_action'(i_action)),
        .i_value    (i_value),
        .i_capacity (r_capacity),
        .o_busy     (busy),
        .o_strobe   (o_strobe),
        .o_status   (w_status),
        .o_word     (o_word),
        .o_last     (o_last),
        .o_count    (w_count),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    assign o_status = w_status;

    // Ring store
    bfs_mem #(
        .DEPTH (DEPTH),
        .WIDTH (bfs_pkg::WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Checks
    a_enq_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == bfs_pkg::ACT_ENQ) |=>
        (o_strobe && o_last &&
         (o_status == bfs_pkg::ST_ENQ || o_status == bfs_pkg::ST_OVF)))
        else $error("enqueue did not complete in one cycle");

    a_busy_ends_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_strobe && o_last))
        else $error("request finished without a final result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_count <= CW'(DEPTH)))
        else $error("fill count beyond ring depth");

    a_dump_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == bfs_pkg::ST_DWORD) |-> (busy && !o_last))
        else $error("dump word without pending terminator");

endmodule

// File: bench/bfs_checker.sv
// Checker for the bounded queue: watches requests and register traffic, predicts results.
`timescale 1ns / 1ps
module bfs_checker #(
    parameter int DEPTH = bfs_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [2:0]                        i_paddr,
    input  logic [31:0]                       i_pwdata,
    input  logic [31:0]                       i_prdata,
    input  logic                              i_pready,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [1:0]                        i_action,
    input  logic signed [bfs_pkg::WORD_W-1:0] i_value,
    input  logic                              i_strobe,
    input  logic [2:0]                        i_status,
    input  logic signed [bfs_pkg::WORD_W-1:0] i_word,
    input  logic                              i_last,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked
);
    import bfs_pkg::*;

    localparam int CAPACITY_REG = 0;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } t_queue_result;

    // Shadow of the ring store and its pointers
    logic signed [WORD_W-1:0] ring_words [DEPTH];
    int                       oldest_slot    = 0;
    int                       next_free_slot = 0;
    int                       word_count     = 0;
    logic [CAP_W-1:0]         capacity_reg   = CAP_RESET;
    t_queue_result            awaited_results [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic int step_slot(int slot);
        return (slot + 1 >= DEPTH) ? 0 : slot + 1;
    endfunction

    // Capacity above the ring depth is clipped to the depth
    function automatic int allowed_words();
        return (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
    endfunction

    task automatic await_result(t_status status, logic signed [WORD_W-1:0] word, logic last);
        t_queue_result entry;
        entry.status = status;
        entry.word   = word;
        entry.last   = last;
        awaited_results.push_back(entry);
    endtask

    // Queue behavior for one accepted request
    task automatic apply_request(t_action act, logic signed [WORD_W-1:0] val);
        int slot;
        int n;
        bit hit;
        slot = oldest_slot;
        hit  = 1'b0;
        case (act)
            ACT_ENQ: begin
                if (word_count >= allowed_words()) begin
                    await_result(ST_OVF, '0, 1'b1);
                end else begin
                    ring_words[next_free_slot] = val;
                    next_free_slot = step_slot(next_free_slot);
                    word_count++;
                    await_result(ST_ENQ, val, 1'b1);
                end
            end
            ACT_DEQ: begin
                if (word_count == 0) begin
                    await_result(ST_UNF, '0, 1'b1);
                end else begin
                    await_result(ST_DEQ, ring_words[oldest_slot], 1'b1);
                    oldest_slot = step_slot(oldest_slot);
                    word_count--;
                end
            end
            ACT_DUMP: begin
                for (n = 0; n < word_count; n++) begin
                    await_result(ST_DWORD, ring_words[slot], 1'b0);
                    slot = step_slot(slot);
                end
                await_result(ST_DEND, '0, 1'b1);
            end
            default: begin
                for (n = 0; n < word_count; n++) begin
                    if (ring_words[slot] == val) hit = 1'b1;
                    slot = step_slot(slot);
                end
                if (hit) begin
                    await_result(ST_FOUND, val, 1'b1);
                end else begin
                    await_result(ST_MISS, val, 1'b1);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            oldest_slot    = 0;
            next_free_slot = 0;
            word_count     = 0;
            capacity_reg   = CAP_RESET;
            awaited_results.delete();
        end else begin
            // Results leave first: they belong to items accepted earlier
            if (i_strobe) begin
                if (awaited_results.size() == 0) begin
                    $error("result with nothing awaited: status %0d word %0d last %0d",
                           i_status, i_word, i_last);
                    o_errors++;
                end else begin
                    want = awaited_results.pop_front();
                    o_checked++;
                    if (i_status != want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, i_status);
                        o_errors++;
                    end
                    if (i_word != want.word) begin
                        $error("word mismatch: expected %0d, got %0d", want.word, i_word);
                        o_errors++;
                    end
                    if (i_last != want.last) begin
                        $error("last mismatch: expected %0d, got %0d", want.last, i_last);
                        o_errors++;
                    end
                end
            end

            // Register port: writes update the shadow, reads are checked
            if (i_psel && i_penable && i_pready && (int'(i_paddr >> 2) == CAPACITY_REG)) begin
                if (i_pwrite) begin
                    capacity_reg = i_pwdata[CAP_W-1:0];
                end else if (i_prdata != 32'(capacity_reg)) begin
                    $error("capacity mismatch: expected %0d, got %0d", capacity_reg, i_prdata);
                    o_errors++;
                end
            end

            // Accepted item
            if (i_start && !i_busy) apply_request(t_action'(i_action), i_value);
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: bench/bounded_fifo_with_search_tb.sv
// Testbench top for the bounded queue with search: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module bounded_fifo_with_search_tb;
    import bfs_pkg::*;

    localparam int         DEPTH         = DEPTH_DEF;
    localparam int         STALL_LIMIT   = 3000;
    localparam int         TAIL_CYCLES   = DEPTH + 8;
    localparam logic [2:0] CAPACITY_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR    = 3'd4;

    logic                     i_clk    = 1'b0;
    logic                     i_rst_n  = 1'b0;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [2:0]               paddr    = '0;
    logic [31:0]              pwdata   = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     start    = 1'b0;
    logic                     busy;
    logic [1:0]               i_action = ACT_ENQ;
    logic signed [WORD_W-1:0] i_value  = '0;
    logic                     o_strobe;
    logic [2:0]               o_status;
    logic signed [WORD_W-1:0] o_word;
    logic                     o_last;

    int errors;
    int pending;
    int checked;
    int requests_sent  = 0;
    int random_sent    = 0;
    int settings_used  = 0;
    int stall_cycles   = 0;
    logic signed [WORD_W-1:0] recent_words [$];

    bounded_fifo_with_search #(.DEPTH(DEPTH)) dut (.*);

    bfs_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_psel   (psel),
        .i_penable(penable),
        .i_pwrite (pwrite),
        .i_paddr  (paddr),
        .i_pwdata (pwdata),
        .i_prdata (prdata),
        .i_pready (pready),
        .i_start  (start),
        .i_busy   (busy),
        .i_action (i_action),
        .i_value  (i_value),
        .i_strobe (o_strobe),
        .i_status (o_status),
        .i_word   (o_word),
        .i_last   (o_last),
        .o_errors (errors),
        .o_pending(pending),
        .o_checked(checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: ends the run after too long without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one item and hold it until the block takes it
    task automatic issue(t_action act, logic signed [WORD_W-1:0] val, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests_sent++;
        if (act == ACT_ENQ) begin
            recent_words.push_back(val);
            if (recent_words.size() > 16) void'(recent_words.pop_front());
        end
    endtask

    // Wait until every awaited result is back and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_access(logic write, logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_capacity(int cap);
        settle();
        reg_access(1'b1, CAPACITY_ADDR, 32'(cap));
        reg_access(1'b0, CAPACITY_ADDR, '0);
        settings_used++;
    endtask

    // Mix of a small pool (so searches hit), extremes and full-range words
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 7)) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_probe();
        if (recent_words.size() > 0 && $urandom_range(0, 1) == 1)
            return recent_words[$urandom_range(0, recent_words.size() - 1)];
        return pick_word();
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic run_phase(int cap, int items, int enq_pct, bit steady);
        int      n;
        t_action act;
        set_capacity(cap);
        for (n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < enq_pct) begin
                act = ACT_ENQ;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: act = ACT_DEQ;
                    4, 5, 6, 7: act = ACT_SEARCH;
                    default:    act = ACT_DUMP;
                endcase
            end
            issue(act, (act == ACT_SEARCH) ? pick_probe() : pick_word(), pick_gap(steady));
            random_sent++;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue at reset capacity
        issue(ACT_DUMP,   pick_word(), 0);
        issue(ACT_SEARCH, '0, 0);
        issue(ACT_DEQ,    pick_word(), 1);
        // Extremes of the word, then lookups and a full dump
        issue(ACT_ENQ,    32'h7FFF_FFFF, 0);
        issue(ACT_ENQ,    32'h8000_0000, 0);
        issue(ACT_ENQ,    '0, 2);
        issue(ACT_ENQ,    '1, 0);
        issue(ACT_SEARCH, 32'h8000_0000, 0);
        issue(ACT_SEARCH, 32'h1234_5678, 0);
        issue(ACT_DUMP,   pick_word(), 0);
        repeat (4) issue(ACT_DEQ, pick_word(), 0);
        issue(ACT_DEQ,    pick_word(), 0);

        // Capacity one: second enqueue overflows
        set_capacity(1);
        issue(ACT_ENQ,    32'h5A5A_5A5A, 0);
        issue(ACT_ENQ,    32'hA5A5_A5A5, 0);
        issue(ACT_SEARCH, 32'h5A5A_5A5A, 0);
        issue(ACT_DEQ,    pick_word(), 0);

        // Capacity zero: every enqueue overflows; unmapped address is ignored
        set_capacity(0);
        issue(ACT_ENQ, 32'h0F0F_0F0F, 0);
        settle();
        reg_access(1'b1, SPARE_ADDR, 32'd32);
        reg_access(1'b0, CAPACITY_ADDR, '0);
        issue(ACT_ENQ,  32'hF0F0_F0F0, 0);
        issue(ACT_DUMP, pick_word(), 0);

        // Random part: above depth and filling to full, then draining phases
        run_phase(63, 45, 85, 1'b0);
        run_phase(32, 15, 35, 1'b1);
        run_phase(2, 10, 50, 1'b0);
        run_phase($urandom_range(3, 31), 12, 55, 1'b0);
        run_phase(1, 6, 45, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests (%0d random) over %0d capacity settings", requests_sent,
                 random_sent, settings_used);
        $display("including empty, full, zero and above-depth capacity; %0d results checked",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: bounded_fifo_with_search.f
rtl/bfs_pkg.sv
rtl/bfs_mem.sv
rtl/bfs_ctrl.sv
rtl/bounded_fifo_with_search.sv
bench/bfs_checker.sv
bench/bounded_fifo_with_search_tb.sv
